// ===== hdl/hcs_pkg.sv =====
// Shared types and constants for the Huffman compressed-size unit.
// No dependencies; every other file imports this package.
package hcs_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int ALPHABET_DEF    = 256;
  localparam int WEIGHT_W        = 32;
  localparam int SIZE_W          = 24;
  localparam int CBYTES_W        = 29;
  localparam int BYTE_SHIFT      = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INC,
    ST_GATHER,
    ST_GDRAIN,
    ST_CHECK,
    ST_SCAN,
    ST_SDRAIN,
    ST_SUM,
    ST_MOVE,
    ST_OUT
  } hcs_state_t;

endpackage

// ===== hdl/huffman_compressed_size_unit.sv =====
// Top level of the Huffman compressed-size unit: control sequencer and merge datapath.
// Depends on hcs_pkg, hcs_hist and hcs_wmem.
//
//   channel   direction  signals                                         handshake
//   command   in         data_byte, last                                 start & !busy
//   result    out        original_size, compressed_bytes, overflow       done (one cycle)
//
// Each byte is a histogram read, then the incremented write-back.
// On the last byte the histogram is swept into the weight memory, then each
// merge with n live weights scans those n entries of the weight memory.
// Synchronous reset clears state, counts and overflow and marks the histogram empty.
// The result is shown for one cycle and cannot be held off by the receiver.
module huffman_compressed_size_unit #(
  parameter int COUNT_WIDTH = hcs_pkg::COUNT_WIDTH_DEF,
  parameter int ALPHABET    = hcs_pkg::ALPHABET_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    data_byte,
  input  logic                          last,
  output logic                          done,
  output logic [hcs_pkg::SIZE_W-1:0]    original_size,
  output logic [hcs_pkg::CBYTES_W-1:0]  compressed_bytes,
  output logic                          overflow
);
  import hcs_pkg::*;

  localparam int IW = $clog2(ALPHABET);
  localparam int NW = $clog2(ALPHABET + 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  hcs_state_t state, state_next;

  logic [COUNT_WIDTH-1:0] byte_count;
  logic [WEIGHT_W-1:0]    bit_total;
  logic                   overflow_seen;
  logic [IW-1:0]          sym;
  logic                   last_q;
  logic                   count_ok;
  logic [IW-1:0]          g;
  logic                   hist_dv;
  logic [NW-1:0]          n;
  logic [IW-1:0]          s;
  logic [IW-1:0]          s_d;
  logic                   w_dv;
  logic [WEIGHT_W:0]      m1, m2;
  logic [IW-1:0]          m1i, m2i;
  logic [WEIGHT_W-1:0]    last_val;

  logic [IW-1:0]          sym_in;
  logic [IW-1:0]          n_last;
  logic [IW-1:0]          lo, hi;
  logic [WEIGHT_W:0]      sum;
  logic [WEIGHT_W+1:0]    total;
  logic [WEIGHT_W:0]      w_ext;

  logic                   h_rd_en, h_wr_en;
  logic [IW-1:0]          h_rd_addr;
  logic [COUNT_WIDTH-1:0] h_rd_data;
  logic                   w_rd_en, w_wr_en;
  logic [IW-1:0]          w_wr_addr;
  logic [WEIGHT_W-1:0]    w_rd_data, w_wr_data;

  // Bytes beyond the alphabet fall into the top bucket.
  assign sym_in = ({1'b0, data_byte} >= 9'(ALPHABET)) ? IW'(ALPHABET - 1) : IW'(data_byte);
  assign n_last = IW'(n - 1'b1);
  assign lo     = (m1i < m2i) ? m1i : m2i;
  assign hi     = (m1i < m2i) ? m2i : m1i;
  assign sum    = {1'b0, m1[WEIGHT_W-1:0]} + {1'b0, m2[WEIGHT_W-1:0]};
  assign total  = {2'b00, bit_total} + {1'b0, sum};
  assign w_ext  = {1'b0, w_rd_data};

  hcs_hist #(
    .ALPHABET   (ALPHABET),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_hist (
    .clk    (clk),
    .rst    (rst),
    .clear  (state == ST_OUT),
    .rd_en  (h_rd_en),
    .rd_addr(h_rd_addr),
    .rd_data(h_rd_data),
    .wr_en  (h_wr_en),
    .wr_addr(sym),
    .wr_data(h_rd_data + 1'b1)
  );

  hcs_wmem #(
    .DEPTH(ALPHABET)
  ) u_wmem (
    .clk    (clk),
    .rd_en  (w_rd_en),
    .rd_addr(s),
    .rd_data(w_rd_data),
    .wr_en  (w_wr_en),
    .wr_addr(w_wr_addr),
    .wr_data(w_wr_data)
  );

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    done       = 1'b0;
    h_rd_en    = 1'b0;
    h_rd_addr  = sym_in;
    h_wr_en    = 1'b0;
    w_rd_en    = 1'b0;
    // Nonzero histogram entries are packed into the weight memory during the sweep.
    w_wr_en    = hist_dv && (h_rd_data != '0);
    w_wr_addr  = IW'(n);
    w_wr_data  = WEIGHT_W'(h_rd_data);
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          h_rd_en    = 1'b1;
          state_next = ST_INC;
        end
      end
      ST_INC: begin
        h_wr_en    = count_ok;
        state_next = last_q ? ST_GATHER : ST_IDLE;
      end
      ST_GATHER: begin
        h_rd_en   = 1'b1;
        h_rd_addr = g;
        if (g == IW'(ALPHABET - 1)) begin
          state_next = ST_GDRAIN;
        end
      end
      ST_GDRAIN: state_next = ST_CHECK;
      ST_CHECK: state_next = (n > NW'(1)) ? ST_SCAN : ST_OUT;
      ST_SCAN: begin
        w_rd_en = 1'b1;
        if (s == n_last) begin
          state_next = ST_SDRAIN;
        end
      end
      ST_SDRAIN: state_next = ST_SUM;
      ST_SUM: begin
        w_wr_en    = 1'b1;
        w_wr_addr  = lo;
        w_wr_data  = WEIGHT_W'(sum);
        state_next = ST_MOVE;
      end
      ST_MOVE: begin
        // The last live weight fills the hole left by the second removed one.
        w_wr_en    = (hi != n_last);
        w_wr_addr  = hi;
        w_wr_data  = last_val;
        state_next = ST_CHECK;
      end
      ST_OUT: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      bit_total     <= '0;
      overflow_seen <= 1'b0;
      hist_dv       <= 1'b0;
      w_dv          <= 1'b0;
    end else begin
      hist_dv <= (state == ST_GATHER);
      w_dv    <= (state == ST_SCAN);
      s_d     <= s;
      if (hist_dv && (h_rd_data != '0)) begin
        n <= n + 1'b1;
      end
      if (w_dv) begin
        if (w_ext < m1) begin
          m2  <= m1;
          m2i <= m1i;
          m1  <= w_ext;
          m1i <= s_d;
        end else if (w_ext < m2) begin
          m2  <= w_ext;
          m2i <= s_d;
        end
        if (s_d == n_last) begin
          last_val <= w_rd_data;
        end
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            sym      <= sym_in;
            last_q   <= last;
            count_ok <= (byte_count != COUNT_MAX);
            if (byte_count == COUNT_MAX) begin
              overflow_seen <= 1'b1;
            end else begin
              byte_count <= byte_count + 1'b1;
            end
          end
          g <= '0;
          n <= '0;
        end
        ST_GATHER: g <= g + 1'b1;
        ST_CHECK: begin
          s  <= '0;
          m1 <= '1;
          m2 <= '1;
        end
        ST_SCAN: s <= s + 1'b1;
        ST_SUM: begin
          if (total > {2'b00, {WEIGHT_W{1'b1}}}) begin
            bit_total     <= '1;
            overflow_seen <= 1'b1;
          end else begin
            bit_total <= WEIGHT_W'(total);
          end
        end
        ST_MOVE: n <= n - 1'b1;
        ST_OUT: begin
          byte_count    <= '0;
          bit_total     <= '0;
          overflow_seen <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign original_size    = SIZE_W'(byte_count);
  assign compressed_bytes = CBYTES_W'(bit_total >> BYTE_SHIFT);
  assign overflow         = overflow_seen;

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe outside a transaction");
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |=> busy)
    else $error("accepted byte did not make the unit busy");
  a_merge_live: assert property (@(posedge clk) disable iff (rst)
      (state == ST_SUM) |-> (n > NW'(1)))
    else $error("merge step with fewer than two weights");
`endif

endmodule

// ===== hdl/hcs_hist.sv =====
// Symbol histogram memory with one registered read port and one write port.
// Per-entry valid bits make the whole histogram read as zero after a clear.
// Depends on hcs_pkg.
module hcs_hist #(
  parameter int ALPHABET    = hcs_pkg::ALPHABET_DEF,
  parameter int COUNT_WIDTH = hcs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  logic                        rd_en,
  input  logic [$clog2(ALPHABET)-1:0] rd_addr,
  output logic [COUNT_WIDTH-1:0]      rd_data,
  input  logic                        wr_en,
  input  logic [$clog2(ALPHABET)-1:0] wr_addr,
  input  logic [COUNT_WIDTH-1:0]      wr_data
);
  import hcs_pkg::*;

  logic [COUNT_WIDTH-1:0] mem [ALPHABET];
  logic [ALPHABET-1:0]    valid;
  logic [COUNT_WIDTH-1:0] rd_q;
  logic                   rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

// ===== hdl/hcs_wmem.sv =====
// Merge weight scratch memory: one write port, one registered read port.
// Depends on hcs_pkg.
module hcs_wmem #(
  parameter int DEPTH = hcs_pkg::ALPHABET_DEF
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [hcs_pkg::WEIGHT_W-1:0]  rd_data,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [hcs_pkg::WEIGHT_W-1:0]  wr_data
);
  import hcs_pkg::*;

  logic [WEIGHT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== test/tb_huffman_compressed_size_unit.sv =====
// Self-checking testbench for huffman_compressed_size_unit: drives byte messages and
// checks message length, coded size in bytes and overflow against a built-in histogram
// and merge predictor. Depends on hcs_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module tb_huffman_compressed_size_unit;
  import hcs_pkg::*;

  localparam longint LEN_MAX   = (64'd1 << COUNT_WIDTH_DEF) - 1;
  localparam longint TOTAL_MAX = 64'hFFFF_FFFF;
  localparam int     CYCLE_LIMIT = 2_000_000;

  typedef struct {
    logic [SIZE_W-1:0]   size;
    logic [CBYTES_W-1:0] cbytes;
    logic                ovf;
  } size_rec_t;

  typedef struct {
    logic [7:0]          sym;
    logic                lst;
    bit                  typed;
    logic [SIZE_W-1:0]   size;
    logic [CBYTES_W-1:0] cbytes;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [7:0] data_byte = '0;
  logic last = 1'b0;
  logic busy, done, overflow;
  logic [SIZE_W-1:0]   original_size;
  logic [CBYTES_W-1:0] compressed_bytes;

  size_rec_t expected_sizes[$];
  longint    sym_hist[ALPHABET_DEF];
  longint    msg_len;
  bit        msg_ovf;
  int        mismatches, results_seen, bytes_sent, messages_sent;
  int        cycles;

  huffman_compressed_size_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .data_byte(data_byte), .last(last), .done(done),
    .original_size(original_size), .compressed_bytes(compressed_bytes),
    .overflow(overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Coded size: repeatedly merge the two lightest weights, summing each merged weight.
  function automatic size_rec_t close_message();
    longint    w[$];
    longint    a, b, total;
    size_rec_t r;
    total = 0;
    for (int i = 0; i < ALPHABET_DEF; i++) begin
      if (sym_hist[i] != 0) w.push_back(sym_hist[i]);
    end
    while (w.size() > 1) begin
      w.sort();
      a = w.pop_front();
      b = w.pop_front();
      total += a + b;
      if (total > TOTAL_MAX) begin
        total = TOTAL_MAX;
        msg_ovf = 1'b1;
      end
      w.push_back(a + b);
    end
    r.size   = msg_len[SIZE_W-1:0];
    r.cbytes = total[CBYTES_W+2:3];
    r.ovf    = msg_ovf;
    foreach (sym_hist[i]) sym_hist[i] = 0;
    msg_len = 0;
    msg_ovf = 1'b0;
    return r;
  endfunction

  function automatic bit count_byte(logic [7:0] sym, logic lst, output size_rec_t r);
    if (msg_len >= LEN_MAX) begin
      msg_ovf = 1'b1;
    end else begin
      msg_len++;
      sym_hist[sym]++;
    end
    if (lst) r = close_message();
    return lst;
  endfunction

  // One transaction; returns once the unit has taken it.
  task automatic send_byte(logic [7:0] sym, logic lst, bit typed = 0,
                           size_rec_t typed_rec = '{default: '0});
    size_rec_t r;
    @(negedge clk);
    start     <= 1'b1;
    data_byte <= sym;
    last      <= lst;
    do @(posedge clk); while (busy);
    bytes_sent++;
    if (count_byte(sym, lst, r)) begin
      messages_sent++;
      expected_sizes.push_back(typed ? typed_rec : r);
    end
  endtask

  task automatic idle_cycles(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Results are strobed for a single cycle; each is checked as it appears.
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (expected_sizes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: size %0d bytes %0d ovf %0b",
                                       original_size, compressed_bytes, overflow);
      end else begin
        size_rec_t e;
        e = expected_sizes.pop_front();
        if (e.size !== original_size || e.cbytes !== compressed_bytes ||
            e.ovf !== overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected size %0d bytes %0d ovf %0b, got %0d %0d %0b",
                     e.size, e.cbytes, e.ovf, original_size, compressed_bytes, overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  row_t dir_rows[$];

  initial begin
    size_rec_t tr;
    int        len, pool_lo, pool_span, burst;
    logic [7:0] sym;
    foreach (sym_hist[i]) sym_hist[i] = 0;
    msg_len = 0;
    msg_ovf = 0;

    // Directed messages; typed rows carry results that follow at a glance.
    dir_rows = '{
      '{8'h00, 1'b1, 1, 24'd1, 29'd0},      // single zero byte
      '{8'hFF, 1'b1, 1, 24'd1, 29'd0},      // single top byte
      '{8'h00, 1'b0, 0, 24'd0, 29'd0},
      '{8'hFF, 1'b1, 1, 24'd2, 29'd0},      // two symbols: 2 bits
      '{8'h41, 1'b0, 0, 24'd0, 29'd0},
      '{8'h41, 1'b0, 0, 24'd0, 29'd0},
      '{8'h41, 1'b1, 1, 24'd3, 29'd0},      // one distinct symbol codes to nothing
      '{8'h01, 1'b0, 0, 24'd0, 29'd0},
      '{8'h02, 1'b0, 0, 24'd0, 29'd0},
      '{8'h04, 1'b0, 0, 24'd0, 29'd0},
      '{8'h08, 1'b0, 0, 24'd0, 29'd0},
      '{8'h10, 1'b0, 0, 24'd0, 29'd0},
      '{8'h20, 1'b0, 0, 24'd0, 29'd0},
      '{8'h40, 1'b0, 0, 24'd0, 29'd0},
      '{8'h80, 1'b1, 1, 24'd8, 29'd3},      // eight equal weights: 24 bits
      '{8'hAA, 1'b0, 0, 24'd0, 29'd0},
      '{8'h55, 1'b0, 0, 24'd0, 29'd0},
      '{8'hAA, 1'b0, 0, 24'd0, 29'd0},
      '{8'h7F, 1'b0, 0, 24'd0, 29'd0},
      '{8'hAA, 1'b1, 0, 24'd0, 29'd0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      tr.size   = dir_rows[i].size;
      tr.cbytes = dir_rows[i].cbytes;
      tr.ovf    = 1'b0;
      send_byte(dir_rows[i].sym, dir_rows[i].lst, dir_rows[i].typed, tr);
    end

    // Two full-alphabet messages, one with skewed weights.
    for (int m = 0; m < 2; m++) begin
      for (int i = 0; i < 256; i++) send_byte(i[7:0], 1'b0);
      for (int i = 0; i < 40; i++)
        send_byte(m ? 8'h00 : 8'($urandom_range(0, 255)), i == 39);
    end

    // Hold off until the unit has drained everything.
    idle_cycles(1);
    wait (expected_sizes.size() == 0);
    idle_cycles($urandom_range(1, 5));

    burst = $urandom_range(1, 30);
    while (bytes_sent < 1850) begin
      case ($urandom_range(0, 9))
        0, 1:    len = $urandom_range(20, 64);
        default: len = $urandom_range(1, 12);
      endcase
      pool_span = $urandom_range(0, 2) == 0 ? 255 : $urandom_range(0, 6);
      pool_lo   = $urandom_range(0, 255 - pool_span);
      for (int i = 0; i < len; i++) begin
        sym = 8'($urandom_range(pool_lo, pool_lo + pool_span));
        send_byte(sym, i == len - 1);
        if (--burst == 0) begin
          if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
          burst = $urandom_range(1, 30);
        end
      end
    end

    idle_cycles(1);
    wait (expected_sizes.size() == 0);
    repeat (50) @(posedge clk);

    $display("Sent %0d bytes in %0d messages, %0d results checked, %0d mismatches.",
             bytes_sent, messages_sent, results_seen, mismatches);
    if (mismatches == 0 && expected_sizes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
